// ----- sv/smf_pkg.sv -----
// smf_pkg: shared types, codes and constants of the format 0 midi file parser
// used by smf_ctrl, smf_dp and smf_track_event_parser; no dependencies
package smf_pkg;

	localparam int DEF_TIME_BITS = 32;
	localparam int CNT_W         = 8;
	localparam int TEMPO_W       = 15;
	localparam int DELTA_W       = 32;
	localparam int TICK_W        = 16;

	localparam logic [TEMPO_W-1:0] TEMPO_RESET = 15'd500;
	localparam logic [TICK_W-1:0]  US_PER_MS   = 16'd1000;

	// request commands
	localparam logic [1:0] CMD_BYTE  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_SKIP  = 2'd2;
	localparam logic [1:0] CMD_NOP   = 2'd3;

	// result status codes
	localparam logic [1:0] ST_BYTE  = 2'd0;
	localparam logic [1:0] ST_EOT   = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_ABORT = 2'd3;

	// byte values
	localparam logic [7:0] B_SYSEX     = 8'hf0;
	localparam logic [7:0] B_SYSEX_ESC = 8'hf7;
	localparam logic [7:0] B_META      = 8'hff;
	localparam logic [7:0] META_TEMPO  = 8'h51;
	localparam logic [7:0] META_EOT    = 8'h2f;
	localparam logic [3:0] HI_NOTE_OFF = 4'h8;
	localparam logic [3:0] HI_NOTE_ON  = 4'h9;
	localparam logic [3:0] HI_POLY_AT  = 4'ha;
	localparam logic [3:0] HI_CTRL     = 4'hb;
	localparam logic [3:0] HI_PROG     = 4'hc;
	localparam logic [3:0] HI_CH_AT    = 4'hd;
	localparam logic [3:0] HI_BEND     = 4'he;
	localparam logic [3:0] CH_LAST     = 4'hf;
	localparam logic [3:0] CH_FIRST    = 4'h0;

	// header byte positions
	localparam logic [CNT_W-1:0] HDR_FMT_HI = 8'd8;
	localparam logic [CNT_W-1:0] HDR_FMT_LO = 8'd9;
	localparam logic [CNT_W-1:0] HDR_DIV_HI = 8'd12;
	localparam logic [CNT_W-1:0] HDR_DIV_LO = 8'd13;
	localparam logic [CNT_W-1:0] HDR_LAST   = 8'd21;
	localparam logic [CNT_W-1:0] TEMPO_LAST = 8'd2;

	typedef enum logic [4:0] {
		PH_IDLE, PH_HDR, PH_DELTA, PH_STATUS, PH_V1, PH_V2, PH_P2, PH_SYSLEN,
		PH_SYSDATA, PH_IGN1, PH_METATYPE, PH_METALEN, PH_METASKIP, PH_TEMPOLEN,
		PH_TEMPO, PH_EOT
	} phase_t;

	typedef enum logic [1:0] {
		EM_DATA, EM_SB, EM_STATUS_BYTE, EM_ZERO
	} emit_sel_t;

	typedef struct packed {
		logic      accept;
		logic      exec;
		phase_t    phase;
		logic      mul;
		logic      div_start;
		logic      div_tempo;
		logic      fin_add;
		logic      fin_tempo;
		logic      emit;
		emit_sel_t emit_sel;
		logic      emit_last;
		logic [1:0] emit_status;
	} dp_cmd_t;

	typedef struct packed {
		logic is_start;
		logic is_skip;
		logic is_byte;
		logic bad_fmt;
		logic bad_div;
		logic hdr_done;
		logic b_cont;
		logic voice3;
		logic prog;
		logic chpress;
		logic sysex;
		logic meta;
		logic drop;
		logic b_zero;
		logic cnt_zero;
		logic cnt_one;
		logic tempo_last;
		logic meta_tempo;
		logic meta_eot;
		logic div_busy;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- sv/smf_div.sv -----
// smf_div: restoring divider, one quotient bit per cycle, 16-bit divisor
// depends on nothing
module smf_div #(
	parameter int W = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [15:0]   divisor,
	output logic          busy,
	output logic [W-1:0]  quotient
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [15:0]   rem_q;
	logic [15:0]   dvs_q;
	logic [W-1:0]  quo_q;
	logic [16:0]   trial;
	logic          ge;

	// shift in next dividend bit and compare
	assign trial = {rem_q, quo_q[W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy_q <= 1'b0;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
endmodule

// ----- sv/smf_dp.sv -----
// smf_dp: parser datapath, item register, counters, timing math, result register
// depends on smf_pkg and smf_div
module smf_dp #(
	parameter int TIME_BITS = smf_pkg::DEF_TIME_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  smf_pkg::dp_cmd_t c,
	output smf_pkg::dp_stat_t s,
	input  logic [1:0]       cmd,
	input  logic [7:0]       data_byte,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       midi_byte,
	output logic [31:0]      due_time_ms,
	output logic             last_of_message,
	output logic [1:0]       status
);
	localparam int DIV_W = (TIME_BITS > 24) ? TIME_BITS : 24;
	localparam int PROD_W = smf_pkg::DELTA_W + smf_pkg::TEMPO_W;
	localparam logic [63:0] TIME_MASK = (TIME_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << TIME_BITS) - 64'd1);

	logic [1:0]                      cmd_q;
	logic [7:0]                      b_q;
	logic                            remap_q;
	logic [smf_pkg::CNT_W-1:0]       cnt_q;
	logic [7:0]                      sbyte_q;
	logic [15:0]                     hword_q;
	logic [smf_pkg::DELTA_W-1:0]     delta_q;
	logic [smf_pkg::TEMPO_W-1:0]     tempo_q;
	logic [smf_pkg::TICK_W-1:0]      ticks_q;
	logic [TIME_BITS-1:0]            elapsed_q;
	logic [PROD_W-1:0]               prod_s1;
	logic                            out_valid_q;
	logic [7:0]                      obyte_q;
	logic [31:0]                     odue_q;
	logic                            olast_q;
	logic [1:0]                      ostat_q;

	logic [3:0]                      hi, ch;
	logic                            hdr_win;
	logic [15:0]                     hw_next;
	logic [7:0]                      sb;
	logic [smf_pkg::DELTA_W-1:0]     tempo_val;
	logic [63:0]                     prod_m, tempo_ext, el_ext;
	logic [DIV_W-1:0]                dividend, quo;
	logic [15:0]                     divisor;
	logic                            div_busy;

	// item decode
	assign hi      = b_q[7:4];
	assign ch      = b_q[3:0];
	assign hdr_win = (cnt_q == smf_pkg::HDR_FMT_HI) || (cnt_q == smf_pkg::HDR_FMT_LO) ||
		(cnt_q == smf_pkg::HDR_DIV_HI) || (cnt_q == smf_pkg::HDR_DIV_LO);
	assign hw_next = hdr_win ? {hword_q[7:0], b_q} : hword_q;

	assign s.is_start   = cmd_q == smf_pkg::CMD_START;
	assign s.is_skip    = cmd_q == smf_pkg::CMD_SKIP;
	assign s.is_byte    = cmd_q == smf_pkg::CMD_BYTE;
	assign s.bad_fmt    = (cnt_q == smf_pkg::HDR_FMT_LO) && (hw_next > 16'd1);
	assign s.bad_div    = (cnt_q == smf_pkg::HDR_DIV_LO) && (hw_next == 16'd0);
	assign s.hdr_done   = cnt_q == smf_pkg::HDR_LAST;
	assign s.b_cont     = b_q[7];
	assign s.voice3     = (hi == smf_pkg::HI_NOTE_OFF) || (hi == smf_pkg::HI_NOTE_ON) ||
		(hi == smf_pkg::HI_POLY_AT) || (hi == smf_pkg::HI_CTRL) || (hi == smf_pkg::HI_BEND);
	assign s.prog       = hi == smf_pkg::HI_PROG;
	assign s.chpress    = hi == smf_pkg::HI_CH_AT;
	assign s.sysex      = (b_q == smf_pkg::B_SYSEX) || (b_q == smf_pkg::B_SYSEX_ESC);
	assign s.meta       = b_q == smf_pkg::B_META;
	assign s.drop       = remap_q && (ch == smf_pkg::CH_LAST);
	assign s.b_zero     = b_q == 8'd0;
	assign s.cnt_zero   = cnt_q == '0;
	assign s.cnt_one    = cnt_q == smf_pkg::CNT_W'(1);
	assign s.tempo_last = cnt_q == smf_pkg::TEMPO_LAST;
	assign s.meta_tempo = b_q == smf_pkg::META_TEMPO;
	assign s.meta_eot   = b_q == smf_pkg::META_EOT;
	assign s.div_busy   = div_busy;
	assign s.out_free   = !out_valid_q || !out_stall;

	// with remap on, channel 1 moves to 16 on three-byte voice and program messages
	assign sb = (remap_q && (ch == smf_pkg::CH_FIRST) && (s.voice3 || s.prog)) ?
		(b_q | 8'h0f) : b_q;
	assign tempo_val = {8'd0, delta_q[15:0], b_q};

	// divider operands
	assign prod_m    = 64'(prod_s1) & TIME_MASK;
	assign tempo_ext = 64'(tempo_val);
	assign dividend  = c.div_tempo ? tempo_ext[DIV_W-1:0] : prod_m[DIV_W-1:0];
	assign divisor   = c.div_tempo ? smf_pkg::US_PER_MS : ticks_q;

	smf_div #(.W(DIV_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(c.div_start), .dividend(dividend),
		.divisor(divisor), .busy(div_busy), .quotient(quo)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) remap_q <= 1'b0;
		else if (cfg_we) remap_q <= cfg_wdata;
	end

	// request register
	always_ff @(posedge clk) begin
		if (c.accept) begin
			cmd_q <= cmd;
			b_q   <= data_byte;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			sbyte_q   <= '0;
			hword_q   <= '0;
			delta_q   <= '0;
			tempo_q   <= smf_pkg::TEMPO_RESET;
			ticks_q   <= '0;
			elapsed_q <= '0;
		end else if (c.exec && s.is_start) begin
			cnt_q     <= '0;
			sbyte_q   <= '0;
			hword_q   <= '0;
			delta_q   <= '0;
			tempo_q   <= smf_pkg::TEMPO_RESET;
			ticks_q   <= '0;
			elapsed_q <= '0;
		end else if (c.exec && s.is_byte) begin
			case (c.phase)
				smf_pkg::PH_HDR: begin
					hword_q <= hw_next;
					if (cnt_q == smf_pkg::HDR_DIV_LO) ticks_q <= hw_next;
					if (!s.bad_fmt && !s.bad_div) begin
						if (s.hdr_done) begin
							cnt_q   <= '0;
							delta_q <= '0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				smf_pkg::PH_DELTA: delta_q <= {delta_q[24:0], b_q[6:0]};
				smf_pkg::PH_STATUS: begin
					sbyte_q <= sb;
					if (s.voice3) cnt_q <= smf_pkg::CNT_W'(s.drop);
				end
				smf_pkg::PH_V2, smf_pkg::PH_P2, smf_pkg::PH_IGN1,
				smf_pkg::PH_TEMPOLEN: begin
					cnt_q   <= '0;
					delta_q <= '0;
				end
				smf_pkg::PH_SYSLEN, smf_pkg::PH_METALEN: begin
					if (s.b_zero) delta_q <= '0;
					cnt_q <= b_q;
				end
				smf_pkg::PH_SYSDATA, smf_pkg::PH_METASKIP: begin
					cnt_q <= cnt_q - 1'b1;
					if (s.cnt_one) delta_q <= '0;
				end
				smf_pkg::PH_TEMPO: begin
					if (s.tempo_last) begin
						cnt_q   <= '0;
						delta_q <= '0;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						delta_q <= tempo_val;
					end
				end
				default: ;
			endcase
		end else if (c.fin_add) begin
			if (ticks_q != '0) elapsed_q <= elapsed_q + quo[TIME_BITS-1:0];
		end else if (c.fin_tempo) begin
			tempo_q <= quo[smf_pkg::TEMPO_W-1:0];
		end
	end

	// product stage
	always_ff @(posedge clk) begin
		if (c.mul) prod_s1 <= PROD_W'(delta_q) * PROD_W'(tempo_q);
	end

	// result register
	assign el_ext = 64'(elapsed_q);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (c.emit) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (c.emit) begin
			case (c.emit_sel)
				smf_pkg::EM_DATA:        obyte_q <= b_q;
				smf_pkg::EM_SB:          obyte_q <= sb;
				smf_pkg::EM_STATUS_BYTE: obyte_q <= sbyte_q;
				default:                 obyte_q <= 8'd0;
			endcase
			odue_q  <= el_ext[31:0];
			olast_q <= c.emit_last;
			ostat_q <= c.emit_status;
		end
	end

	assign out_valid       = out_valid_q;
	assign midi_byte       = obyte_q;
	assign due_time_ms     = odue_q;
	assign last_of_message = olast_q;
	assign status          = ostat_q;
endmodule

// ----- sv/smf_ctrl.sv -----
// smf_ctrl: parse phase and cycle sequencer of the midi file parser
// depends on smf_pkg; drives smf_dp through dp_cmd_t
module smf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  smf_pkg::dp_stat_t s,
	output smf_pkg::dp_cmd_t  c
);
	typedef enum logic [2:0] {
		C_READY, C_EXEC, C_MUL, C_DSTART, C_DIV, C_FIN
	} cstate_t;

	cstate_t           st_q;
	logic              fin_tempo_q;
	smf_pkg::phase_t   phase_q, phase_nx;
	logic              em, em_last, go, do_mul, do_tempo;
	smf_pkg::emit_sel_t em_sel;
	logic [1:0]        em_stat;

	// next phase and result for the request in hand
	always_comb begin
		phase_nx = phase_q;
		em       = 1'b0;
		em_sel   = smf_pkg::EM_DATA;
		em_last  = 1'b0;
		em_stat  = smf_pkg::ST_BYTE;
		do_mul   = 1'b0;
		do_tempo = 1'b0;
		if (s.is_start) begin
			phase_nx = smf_pkg::PH_HDR;
		end else if (s.is_skip) begin
			if (phase_q != smf_pkg::PH_IDLE) begin
				phase_nx = smf_pkg::PH_IDLE;
				em       = 1'b1;
				em_sel   = smf_pkg::EM_ZERO;
				em_stat  = smf_pkg::ST_ABORT;
			end
		end else if (s.is_byte) begin
			case (phase_q)
				smf_pkg::PH_HDR: begin
					if (s.bad_fmt || s.bad_div) begin
						phase_nx = smf_pkg::PH_IDLE;
						em       = 1'b1;
						em_sel   = smf_pkg::EM_ZERO;
						em_stat  = smf_pkg::ST_BAD;
					end else if (s.hdr_done) begin
						phase_nx = smf_pkg::PH_DELTA;
					end
				end
				smf_pkg::PH_DELTA: begin
					if (!s.b_cont) begin
						phase_nx = smf_pkg::PH_STATUS;
						do_mul   = 1'b1;
					end
				end
				smf_pkg::PH_STATUS: begin
					if (s.voice3) begin
						phase_nx = smf_pkg::PH_V1;
						em       = !s.drop;
						em_sel   = smf_pkg::EM_SB;
					end else if (s.prog || s.chpress) begin
						phase_nx = smf_pkg::PH_P2;
						em       = 1'b1;
						em_sel   = smf_pkg::EM_SB;
					end else if (s.sysex) begin
						phase_nx = smf_pkg::PH_SYSLEN;
					end else if (s.meta) begin
						phase_nx = smf_pkg::PH_METATYPE;
					end else begin
						phase_nx = smf_pkg::PH_IGN1;
					end
				end
				smf_pkg::PH_V1: begin
					phase_nx = smf_pkg::PH_V2;
					em       = s.cnt_zero;
				end
				smf_pkg::PH_V2: begin
					phase_nx = smf_pkg::PH_DELTA;
					em       = s.cnt_zero;
					em_last  = 1'b1;
				end
				smf_pkg::PH_P2: begin
					phase_nx = smf_pkg::PH_DELTA;
					em       = 1'b1;
					em_last  = 1'b1;
				end
				smf_pkg::PH_SYSLEN: begin
					phase_nx = s.b_zero ? smf_pkg::PH_DELTA : smf_pkg::PH_SYSDATA;
					em       = 1'b1;
					em_sel   = smf_pkg::EM_STATUS_BYTE;
					em_last  = s.b_zero;
				end
				smf_pkg::PH_SYSDATA: begin
					if (s.cnt_one) phase_nx = smf_pkg::PH_DELTA;
					em      = 1'b1;
					em_last = s.cnt_one;
				end
				smf_pkg::PH_IGN1: phase_nx = smf_pkg::PH_DELTA;
				smf_pkg::PH_METATYPE: begin
					if (s.meta_tempo) phase_nx = smf_pkg::PH_TEMPOLEN;
					else if (s.meta_eot) phase_nx = smf_pkg::PH_EOT;
					else phase_nx = smf_pkg::PH_METALEN;
				end
				smf_pkg::PH_METALEN:
					phase_nx = s.b_zero ? smf_pkg::PH_DELTA : smf_pkg::PH_METASKIP;
				smf_pkg::PH_METASKIP: begin
					if (s.cnt_one) phase_nx = smf_pkg::PH_DELTA;
				end
				smf_pkg::PH_TEMPOLEN: phase_nx = smf_pkg::PH_TEMPO;
				smf_pkg::PH_TEMPO: begin
					if (s.tempo_last) begin
						phase_nx = smf_pkg::PH_DELTA;
						do_tempo = 1'b1;
					end
				end
				smf_pkg::PH_EOT: begin
					phase_nx = smf_pkg::PH_IDLE;
					em       = 1'b1;
					em_sel   = smf_pkg::EM_ZERO;
					em_stat  = smf_pkg::ST_EOT;
				end
				default: ;
			endcase
		end
	end

	// hold in exec while a result has no room
	assign go = (st_q == C_EXEC) && (!em || s.out_free);

	// commands to the datapath
	always_comb begin
		c             = '0;
		c.accept      = (st_q == C_READY) && in_valid;
		c.exec        = go;
		c.phase       = phase_q;
		c.mul         = st_q == C_MUL;
		c.div_start   = (go && do_tempo) || (st_q == C_DSTART);
		c.div_tempo   = go && do_tempo;
		c.fin_add     = (st_q == C_FIN) && !fin_tempo_q;
		c.fin_tempo   = (st_q == C_FIN) && fin_tempo_q;
		c.emit        = go && em;
		c.emit_sel    = em_sel;
		c.emit_last   = em_last;
		c.emit_status = em_stat;
	end

	assign in_stall = st_q != C_READY;

	// sequencer and parse phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= C_READY;
			phase_q     <= smf_pkg::PH_IDLE;
			fin_tempo_q <= 1'b0;
		end else begin
			case (st_q)
				C_READY: if (in_valid) st_q <= C_EXEC;
				C_EXEC: begin
					if (go) begin
						phase_q <= phase_nx;
						if (do_mul) begin
							st_q        <= C_MUL;
							fin_tempo_q <= 1'b0;
						end else if (do_tempo) begin
							st_q        <= C_DIV;
							fin_tempo_q <= 1'b1;
						end else begin
							st_q <= C_READY;
						end
					end
				end
				C_MUL:    st_q <= C_DSTART;
				C_DSTART: st_q <= C_DIV;
				C_DIV:    if (!s.div_busy) st_q <= C_FIN;
				C_FIN:    st_q <= C_READY;
				default:  st_q <= C_READY;
			endcase
		end
	end

	// checks
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		c.emit |-> s.out_free) else $error("result loaded into a full output register");
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		c.div_start |-> !s.div_busy) else $error("divider restarted while busy");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == C_FIN) |-> !s.div_busy) else $error("quotient used before done");
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (st_q == C_EXEC)) else $error("request lost");
endmodule

// ----- sv/smf_track_event_parser.sv -----
// smf_track_event_parser: top level of the format 0 midi file parser
// depends on smf_pkg, smf_ctrl, smf_dp, smf_div
//
// channel   signals                                       direction
// request   in_valid, in_stall, cmd, data_byte            in
// result    out_valid, out_stall, midi_byte, due_time_ms,  out
//           last_of_message, status
// config    cfg_we, cfg_wdata                              in
//
// a request passes the ready and exec states, a delta time end adds mul, dstart,
// div and fin, a tempo event end div and fin; div holds while the divider runs
// asynchronous reset clears parser state, tempo to 500 and remap off
// a request is accepted while an earlier result still waits in the output register
// a new result waits inside the block while out_stall holds the previous one
module smf_track_event_parser #(
	parameter int TIME_BITS = smf_pkg::DEF_TIME_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  midi_byte,
	output logic [31:0] due_time_ms,
	output logic        last_of_message,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	smf_pkg::dp_cmd_t  dp_c;
	smf_pkg::dp_stat_t dp_s;

	smf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.s(dp_s), .c(dp_c)
	);

	smf_dp #(.TIME_BITS(TIME_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .c(dp_c), .s(dp_s), .cmd(cmd),
		.data_byte(data_byte), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.out_valid(out_valid), .out_stall(out_stall), .midi_byte(midi_byte),
		.due_time_ms(due_time_ms), .last_of_message(last_of_message), .status(status)
	);
endmodule

// ----- tb/sv/testbench.sv -----
// testbench: self-checking bench for smf_track_event_parser
// depends on smf_pkg and the parser rtl; holds its own file parser predictor
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic [7:0]  mbyte;
		logic [31:0] due;
		logic        last;
		logic [1:0]  st;
	} midi_result_t;

	int error_count = 0;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $time, what);
		error_count++;
	endtask

	// parser predictor plus queue of expected results
	class smf_scoreboard;
		midi_result_t pending[$];
		bit     remap;
		smf_pkg::phase_t ph;
		logic [7:0]  cnt, sbyte;
		logic [15:0] hword;
		logic [31:0] accum;
		logic [14:0] tempo;
		logic [15:0] tpq;
		logic [31:0] elapsed;

		function new();
			remap = 0;
			ph = smf_pkg::PH_IDLE;
			clear_file();
		endfunction

		function void clear_file();
			cnt = 8'd0; sbyte = 8'd0; hword = 16'd0; accum = 32'd0;
			tempo = smf_pkg::TEMPO_RESET; tpq = 16'd0; elapsed = 32'd0;
		endfunction

		function void push(logic [7:0] b, logic l, logic [1:0] s);
			midi_result_t r;
			r.mbyte = b; r.due = elapsed; r.last = l; r.st = s;
			pending.push_back(r);
		endfunction

		function void to_delta();
			ph = smf_pkg::PH_DELTA; accum = 32'd0; cnt = 8'd0;
		endfunction

		// note an accepted request
		function void note_request(logic [1:0] c, logic [7:0] b);
			logic [3:0]  hi, ch;
			logic [7:0]  sb;
			logic [63:0] prod;
			bit          drop;
			if (c == smf_pkg::CMD_START) begin
				ph = smf_pkg::PH_HDR;
				clear_file();
				return;
			end
			if (c == smf_pkg::CMD_SKIP) begin
				if (ph != smf_pkg::PH_IDLE) begin
					ph = smf_pkg::PH_IDLE;
					push(8'd0, 1'b0, smf_pkg::ST_ABORT);
				end
				return;
			end
			if (c != smf_pkg::CMD_BYTE) return;
			hi = b[7:4];
			ch = b[3:0];
			case (ph)
				smf_pkg::PH_HDR: begin
					if (cnt == smf_pkg::HDR_FMT_HI || cnt == smf_pkg::HDR_FMT_LO
						|| cnt == smf_pkg::HDR_DIV_HI || cnt == smf_pkg::HDR_DIV_LO)
						hword = {hword[7:0], b};
					if (cnt == smf_pkg::HDR_FMT_LO && hword > 16'd1) begin
						ph = smf_pkg::PH_IDLE;
						push(8'd0, 1'b0, smf_pkg::ST_BAD);
						return;
					end
					if (cnt == smf_pkg::HDR_DIV_LO) begin
						tpq = hword;
						if (tpq == 16'd0) begin
							ph = smf_pkg::PH_IDLE;
							push(8'd0, 1'b0, smf_pkg::ST_BAD);
							return;
						end
					end
					cnt++;
					if (cnt > smf_pkg::HDR_LAST) to_delta();
				end
				smf_pkg::PH_DELTA: begin
					accum = {accum[24:0], b[6:0]};
					if (!b[7]) begin
						prod = (64'(accum) * 64'(tempo)) & 64'hffff_ffff;
						elapsed = elapsed + 32'(prod / 64'(tpq));
						ph = smf_pkg::PH_STATUS;
					end
				end
				smf_pkg::PH_STATUS: begin
					sbyte = b;
					if (hi inside {smf_pkg::HI_NOTE_OFF, smf_pkg::HI_NOTE_ON,
						smf_pkg::HI_POLY_AT, smf_pkg::HI_CTRL, smf_pkg::HI_BEND}) begin
						drop = remap && ch == smf_pkg::CH_LAST;
						sb = (remap && ch == smf_pkg::CH_FIRST) ? (b | 8'h0f) : b;
						sbyte = sb;
						cnt = 8'(drop);
						ph = smf_pkg::PH_V1;
						if (!drop) push(sb, 1'b0, smf_pkg::ST_BYTE);
					end else if (hi == smf_pkg::HI_PROG) begin
						sb = (remap && ch == smf_pkg::CH_FIRST) ? (b | 8'h0f) : b;
						sbyte = sb;
						ph = smf_pkg::PH_P2;
						push(sb, 1'b0, smf_pkg::ST_BYTE);
					end else if (hi == smf_pkg::HI_CH_AT) begin
						ph = smf_pkg::PH_P2;
						push(b, 1'b0, smf_pkg::ST_BYTE);
					end else if (b == smf_pkg::B_SYSEX || b == smf_pkg::B_SYSEX_ESC)
						ph = smf_pkg::PH_SYSLEN;
					else if (b == smf_pkg::B_META) ph = smf_pkg::PH_METATYPE;
					else ph = smf_pkg::PH_IGN1;
				end
				smf_pkg::PH_V1: begin
					ph = smf_pkg::PH_V2;
					if (cnt == 8'd0) push(b, 1'b0, smf_pkg::ST_BYTE);
				end
				smf_pkg::PH_V2: begin
					drop = cnt != 8'd0;
					to_delta();
					if (!drop) push(b, 1'b1, smf_pkg::ST_BYTE);
				end
				smf_pkg::PH_P2: begin
					to_delta();
					push(b, 1'b1, smf_pkg::ST_BYTE);
				end
				smf_pkg::PH_SYSLEN: begin
					if (b == 8'd0) to_delta();
					else begin
						cnt = b;
						ph = smf_pkg::PH_SYSDATA;
					end
					push(sbyte, b == 8'd0, smf_pkg::ST_BYTE);
				end
				smf_pkg::PH_SYSDATA: begin
					cnt--;
					if (cnt == 8'd0) to_delta();
					push(b, cnt == 8'd0, smf_pkg::ST_BYTE);
				end
				smf_pkg::PH_IGN1: to_delta();
				smf_pkg::PH_METATYPE: begin
					if (b == smf_pkg::META_TEMPO) ph = smf_pkg::PH_TEMPOLEN;
					else if (b == smf_pkg::META_EOT) ph = smf_pkg::PH_EOT;
					else ph = smf_pkg::PH_METALEN;
				end
				smf_pkg::PH_METALEN: begin
					if (b == 8'd0) to_delta();
					else begin
						cnt = b;
						ph = smf_pkg::PH_METASKIP;
					end
				end
				smf_pkg::PH_METASKIP: begin
					cnt--;
					if (cnt == 8'd0) to_delta();
				end
				smf_pkg::PH_TEMPOLEN: begin
					accum = 32'd0; cnt = 8'd0; ph = smf_pkg::PH_TEMPO;
				end
				smf_pkg::PH_TEMPO: begin
					accum = {8'h00, accum[15:0], b};
					cnt++;
					if (cnt >= 8'd3) begin
						tempo = 15'(accum / 32'd1000);
						to_delta();
					end
				end
				smf_pkg::PH_EOT: begin
					ph = smf_pkg::PH_IDLE;
					push(8'd0, 1'b0, smf_pkg::ST_EOT);
				end
				default: ;
			endcase
		endfunction

		// compare one accepted result with the oldest expectation
		task check_result(midi_result_t got);
			midi_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = pending.pop_front();
			if (got.mbyte !== want.mbyte)
				report($sformatf("midi_byte %h want %h", got.mbyte, want.mbyte));
			if (got.due !== want.due)
				report($sformatf("due_time_ms %0d want %0d", got.due, want.due));
			if (got.last !== want.last)
				report($sformatf("last_of_message %b want %b", got.last, want.last));
			if (got.st !== want.st)
				report($sformatf("status %0d want %0d", got.st, want.st));
		endtask
	endclass

	logic        clk = 0, arst_n = 0;
	logic        in_valid = 0, out_stall = 0;
	logic [1:0]  cmd = smf_pkg::CMD_BYTE;
	logic [7:0]  data_byte = 0;
	logic        cfg_we = 0, cfg_wdata = 0;
	logic        in_stall, out_valid, last_of_message;
	logic [7:0]  midi_byte;
	logic [31:0] due_time_ms;
	logic [1:0]  status;

	smf_track_event_parser dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall), .midi_byte(midi_byte),
		.due_time_ms(due_time_ms), .last_of_message(last_of_message), .status(status),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	smf_scoreboard sb = new();
	int  idle_cycles = 0;
	int  sent = 0;
	bit  quiet = 0;
	bit  paused = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// result side: sample at rising edge, random stall at falling edge
	always @(posedge clk) begin
		midi_result_t r;
		if (out_valid && !out_stall) begin
			r = '{midi_byte, due_time_ms, last_of_message, status};
			sb.check_result(r);
		end
	end

	initial begin
		int wait_n;
		forever begin
			@(negedge clk);
			if (quiet || $urandom_range(0, 3) != 0) out_stall <= 0;
			else begin
				wait_n = $urandom_range(1, 13);
				out_stall <= 1;
				repeat (wait_n - 1) @(negedge clk);
				@(negedge clk);
				out_stall <= 0;
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// one request; valid stays up after acceptance until the next falling edge
	task automatic send(input logic [1:0] c, input logic [7:0] b);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0) gap = 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		data_byte <= b;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(c, b);
		sent++;
	endtask

	// drop valid after the last request
	task automatic hold_input();
		@(negedge clk);
		in_valid <= 0;
	endtask

	task automatic drain();
		hold_input();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (120) @(negedge clk);
	endtask

	task automatic set_remap(input bit v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.remap = v;
	endtask

	// header with chosen format and division
	task automatic header(input logic [15:0] fmt, input logic [15:0] div);
		send(smf_pkg::CMD_START, 8'($urandom));
		for (int i = 0; i < 22; i++) begin
			if (i == 8) send(smf_pkg::CMD_BYTE, fmt[15:8]);
			else if (i == 9) send(smf_pkg::CMD_BYTE, fmt[7:0]);
			else if (i == 12) send(smf_pkg::CMD_BYTE, div[15:8]);
			else if (i == 13) send(smf_pkg::CMD_BYTE, div[7:0]);
			else send(smf_pkg::CMD_BYTE, 8'($urandom));
		end
	endtask

	task automatic delta();
		int n;
		n = $urandom_range(0, 4);
		for (int i = 0; i < n; i++) send(smf_pkg::CMD_BYTE, 8'h80 | 8'($urandom));
		send(smf_pkg::CMD_BYTE, 8'($urandom_range(0, 127)));
	endtask

	// one random track event with a leading delta
	task automatic track_event();
		int k, n;
		logic [7:0] s;
		delta();
		k = $urandom_range(0, 19);
		if (k < 8) begin
			s = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
			if ($urandom_range(0, 3) == 0)
				s[3:0] = $urandom_range(0, 1) ? smf_pkg::CH_LAST : smf_pkg::CH_FIRST;
			send(smf_pkg::CMD_BYTE, s);
			if (s[7:4] != smf_pkg::HI_PROG && s[7:4] != smf_pkg::HI_CH_AT)
				send(smf_pkg::CMD_BYTE, 8'($urandom));
			send(smf_pkg::CMD_BYTE, 8'($urandom));
		end else if (k < 11) begin
			n = $urandom_range(0, 5);
			send(smf_pkg::CMD_BYTE, $urandom_range(0, 1) ? smf_pkg::B_SYSEX
				: smf_pkg::B_SYSEX_ESC);
			send(smf_pkg::CMD_BYTE, 8'(n));
			for (int i = 0; i < n; i++) send(smf_pkg::CMD_BYTE, 8'($urandom));
		end else if (k < 14) begin
			send(smf_pkg::CMD_BYTE, smf_pkg::B_META);
			send(smf_pkg::CMD_BYTE, smf_pkg::META_TEMPO);
			send(smf_pkg::CMD_BYTE, 8'd3);
			send(smf_pkg::CMD_BYTE, 8'($urandom));
			send(smf_pkg::CMD_BYTE, 8'($urandom));
			send(smf_pkg::CMD_BYTE, 8'($urandom));
		end else if (k < 16) begin
			n = $urandom_range(0, 4);
			send(smf_pkg::CMD_BYTE, smf_pkg::B_META);
			send(smf_pkg::CMD_BYTE, $urandom_range(0, 1) ? 8'h00 : 8'($urandom));
			send(smf_pkg::CMD_BYTE, 8'(n));
			for (int i = 0; i < n; i++) send(smf_pkg::CMD_BYTE, 8'($urandom));
		end else if (k < 18) begin
			send(smf_pkg::CMD_BYTE, $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
				: 8'($urandom_range(8'hf1, 8'hfe)));
			send(smf_pkg::CMD_BYTE, 8'($urandom));
		end else begin
			send(smf_pkg::CMD_BYTE, 8'($urandom));
		end
	endtask

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// directed: bad headers, skip, end of track, extremes
		header(16'h0002, 16'd96);
		header(16'h0000, 16'h0000);
		header(16'h0001, 16'hffff);
		send(smf_pkg::CMD_BYTE, 8'hff); send(smf_pkg::CMD_BYTE, 8'h7f);
		send(smf_pkg::CMD_BYTE, 8'h90); send(smf_pkg::CMD_BYTE, 8'h3c);
		send(smf_pkg::CMD_BYTE, 8'h7f);
		send(smf_pkg::CMD_BYTE, 8'h00); send(smf_pkg::CMD_BYTE, smf_pkg::B_META);
		send(smf_pkg::CMD_BYTE, smf_pkg::META_TEMPO);
		send(smf_pkg::CMD_BYTE, 8'd3); send(smf_pkg::CMD_BYTE, 8'hff);
		send(smf_pkg::CMD_BYTE, 8'hff); send(smf_pkg::CMD_BYTE, 8'hff);
		send(smf_pkg::CMD_SKIP, 8'd0);
		send(smf_pkg::CMD_SKIP, 8'hff);
		send(smf_pkg::CMD_BYTE, 8'h55);
		send(smf_pkg::CMD_NOP, 8'd0);
		header(16'h0000, 16'd1);
		send(smf_pkg::CMD_BYTE, 8'd0); send(smf_pkg::CMD_BYTE, smf_pkg::B_META);
		send(smf_pkg::CMD_BYTE, smf_pkg::META_EOT);
		send(smf_pkg::CMD_BYTE, 8'd0);

		// random files in four passes, with remap on and off in turn
		for (int ph_i = 0; ph_i < 4; ph_i++) begin
			set_remap(ph_i % 2 == 0);
			while (sent < (ph_i + 1) * 320) begin
				header($urandom_range(0, 15) == 0 ? 16'($urandom) : 16'($urandom_range(0, 1)),
					$urandom_range(0, 15) == 0 ? 16'h0 : 16'($urandom_range(1, 500)));
				for (int e = $urandom_range(2, 20); e > 0; e--) begin
					track_event();
					if ($urandom_range(0, 40) == 0)
						send(2'($urandom_range(1, 3)), 8'($urandom));
				end
				if ($urandom_range(0, 1)) begin
					delta();
					send(smf_pkg::CMD_BYTE, smf_pkg::B_META);
					send(smf_pkg::CMD_BYTE, smf_pkg::META_EOT);
					send(smf_pkg::CMD_BYTE, 8'($urandom));
				end else send(smf_pkg::CMD_SKIP, 8'($urandom));
				if (sent > 600 && !paused) begin
					// hold the sender until the parser has emptied
					hold_input();
					while (sb.pending.size() != 0) @(negedge clk);
					paused = 1;
				end
				if (ph_i == 2) quiet = ~quiet;
			end
		end
		quiet = 0;
		drain();
		if (error_count == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
